// File: rtl/max_heap_priority_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// max heap priority queue assertion macros
// shared property forms for the heap sequencer checks
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mhpq_pkg.sv
// ----------------------------------------------------------------------------
// mhpq_pkg
// types, codes and defaults shared by the max heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

	localparam int DEF_CAPACITY = 16;

	localparam logic FN_APPEND  = 1'b0;
	localparam logic FN_EXTRACT = 1'b1;

	localparam logic [1:0] ST_STORED    = 2'd0;
	localparam logic [1:0] ST_EXTRACTED = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	typedef struct packed {
		logic [31:0] key;
		logic [30:0] id;
		logic [3:0]  doors;
		logic [7:0]  series;
	} entry_t;

	typedef struct packed {
		logic   func;
		entry_t entry;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] key;
		logic [31:0] id;
		logic [3:0]  doors;
		logic [7:0]  series;
	} res_t;

endpackage

// File: rtl/max_heap_priority_queue_unit.sv
// append or empty extract: the sequencer goes from idle straight to done, the result is then registered at the output
// extract on a built heap: root read, last entry read, then the last entry sinks from the root level by level
// a first extract after appends adds a bottom-up heapify
// throughput: one request in flight, the next is taken once the result leaves the sequencer
// reset: heap empty and marked built, entry store contents left undefined
// ----------------------------------------------------------------------------
// max_heap_priority_queue_unit
// binary max-heap on a 32-bit price key with id, door count and series payload
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [31:0]        item_key,
	input  logic [30:0]        item_id,
	input  logic [3:0]         item_doors,
	input  logic [7:0]         item_series,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        out_key,
	output logic signed [31:0] out_id,
	output logic [3:0]         out_doors,
	output logic [7:0]         out_series
);

	mhpq_pkg::req_t req;
	mhpq_pkg::res_t res;
	mhpq_pkg::res_t out_q;
	logic           idle;
	logic           res_valid;
	logic           res_ready;
	logic           out_valid_q;

	assign req.func         = func;
	assign req.entry.key    = item_key;
	assign req.entry.id     = item_id;
	assign req.entry.doors  = item_doors;
	assign req.entry.series = item_series;

	assign in_ready  = idle;
	assign res_ready = !out_valid_q || out_ready;

	mhpq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req),
		.idle      (idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, frees the sequencer while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			out_q       <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign out_key    = out_q.key;
	assign out_id     = out_q.id;
	assign out_doors  = out_q.doors;
	assign out_series = out_q.series;

endmodule

// File: rtl/mhpq_mem.sv
// ----------------------------------------------------------------------------
// mhpq_mem
// heap entry store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mhpq_mem #(
	parameter int DEPTH = mhpq_pkg::DEF_CAPACITY,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  mhpq_pkg::entry_t    wdata,
	input  logic [AW-1:0]       raddr,
	output mhpq_pkg::entry_t    rdata
);

	mhpq_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/mhpq_ctrl.sv
// ----------------------------------------------------------------------------
// mhpq_ctrl
// heap sequencer: append, bottom-up heapify and extract with sift-down,
// one shared key comparator, entries held in mhpq_mem
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_unit_assert.svh"

module mhpq_ctrl #(
	parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  mhpq_pkg::req_t  req,
	output logic            idle,
	output logic            res_valid,
	input  logic            res_ready,
	output mhpq_pkg::res_t  res
);

	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int CHW = AW + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_HEAP_NEXT,
		S_HEAP_LD,
		S_EX_ROOT,
		S_EX_LAST,
		S_EX_LD,
		S_SIFT_L,
		S_SIFT_R,
		S_SIFT_C,
		S_SIFT_W,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               built_q;
	logic               heap_q;
	logic [CW-1:0]      hz_q;
	logic [AW-1:0]      node_q;
	logic [AW-1:0]      best_idx_q;
	logic               best_is_cur_q;
	mhpq_pkg::entry_t   cur_q;
	mhpq_pkg::entry_t   best_q;
	mhpq_pkg::res_t     res_q;

	logic               we;
	logic [AW-1:0]      waddr;
	mhpq_pkg::entry_t   wdata;
	logic [AW-1:0]      raddr;
	mhpq_pkg::entry_t   rd_data;

	logic [CHW-1:0]     left_w;
	logic [CHW-1:0]     right_w;
	logic [CHW-1:0]     cnt_x;
	logic               left_in;
	logic               right_in;
	logic               full;
	logic               append_go;
	logic [31:0]        cmp_a;
	logic               cmp_gt;

	mhpq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign left_w    = {1'b0, node_q, 1'b1};
	assign right_w   = left_w + CHW'(1);
	assign cnt_x     = {{(CHW-CW){1'b0}}, count_q};
	assign left_in   = left_w < cnt_x;
	assign right_in  = right_w < cnt_x;
	assign full      = count_q == CW'(CAPACITY);
	assign append_go = state_q == S_IDLE && req_valid && req.func == mhpq_pkg::FN_APPEND && !full;

	// shared comparator: child key strictly above the current winner
	assign cmp_a  = (state_q == S_SIFT_R) ? cur_q.key : best_q.key;
	assign cmp_gt = rd_data.key > cmp_a;

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_DONE;
	assign res       = res_q;

	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = cur_q;
		raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (append_go) begin
					we    = 1'b1;
					waddr = AW'(count_q);
					wdata = req.entry;
				end
			end
			S_HEAP_NEXT: raddr = AW'(hz_q - CW'(1));
			S_EX_LAST:   raddr = AW'(count_q - CW'(1));
			S_SIFT_L: begin
				if (left_in) begin
					raddr = left_w[AW-1:0];
				end else begin
					// leaf reached, drop the sinking entry into the hole
					we = 1'b1;
				end
			end
			S_SIFT_R: begin
				if (right_in) begin
					raddr = right_w[AW-1:0];
				end
			end
			S_SIFT_W: begin
				we    = 1'b1;
				wdata = best_is_cur_q ? cur_q : best_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			built_q       <= 1'b1;
			heap_q        <= 1'b0;
			hz_q          <= '0;
			node_q        <= '0;
			best_idx_q    <= '0;
			best_is_cur_q <= 1'b1;
			cur_q         <= '0;
			best_q        <= '0;
			res_q         <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.func == mhpq_pkg::FN_APPEND) begin
							if (full) begin
								res_q <= '{status: mhpq_pkg::ST_FULL, key: '0, id: '0,
									doors: '0, series: '0};
							end else begin
								res_q   <= '{status: mhpq_pkg::ST_STORED, key: '0, id: '0,
									doors: '0, series: '0};
								count_q <= count_q + CW'(1);
								built_q <= 1'b0;
							end
							state_q <= S_DONE;
						end else if (count_q == '0) begin
							res_q   <= '{status: mhpq_pkg::ST_EMPTY, key: '0, id: '1,
								doors: '0, series: '0};
							state_q <= S_DONE;
						end else if (!built_q) begin
							hz_q    <= count_q >> 1;
							heap_q  <= 1'b1;
							state_q <= S_HEAP_NEXT;
						end else begin
							heap_q  <= 1'b0;
							state_q <= S_EX_ROOT;
						end
					end
				end
				S_HEAP_NEXT: begin
					if (hz_q == '0) begin
						built_q <= 1'b1;
						heap_q  <= 1'b0;
						state_q <= S_EX_ROOT;
					end else begin
						node_q  <= AW'(hz_q - CW'(1));
						hz_q    <= hz_q - CW'(1);
						state_q <= S_HEAP_LD;
					end
				end
				S_HEAP_LD: begin
					cur_q   <= rd_data;
					state_q <= S_SIFT_L;
				end
				S_EX_ROOT: state_q <= S_EX_LAST;
				S_EX_LAST: begin
					res_q   <= '{status: mhpq_pkg::ST_EXTRACTED, key: rd_data.key,
						id: {1'b0, rd_data.id}, doors: rd_data.doors,
						series: rd_data.series};
					state_q <= S_EX_LD;
				end
				S_EX_LD: begin
					// last entry becomes the sinking entry, root is the hole
					cur_q   <= rd_data;
					count_q <= count_q - CW'(1);
					node_q  <= '0;
					state_q <= S_SIFT_L;
				end
				S_SIFT_L: begin
					if (left_in) begin
						state_q <= S_SIFT_R;
					end else begin
						state_q <= heap_q ? S_HEAP_NEXT : S_DONE;
					end
				end
				S_SIFT_R: begin
					if (cmp_gt) begin
						best_q        <= rd_data;
						best_idx_q    <= left_w[AW-1:0];
						best_is_cur_q <= 1'b0;
					end else begin
						best_q        <= cur_q;
						best_is_cur_q <= 1'b1;
					end
					state_q <= right_in ? S_SIFT_C : S_SIFT_W;
				end
				S_SIFT_C: begin
					if (cmp_gt) begin
						best_q        <= rd_data;
						best_idx_q    <= right_w[AW-1:0];
						best_is_cur_q <= 1'b0;
					end
					state_q <= S_SIFT_W;
				end
				S_SIFT_W: begin
					if (best_is_cur_q) begin
						state_q <= heap_q ? S_HEAP_NEXT : S_DONE;
					end else begin
						node_q  <= best_idx_q;
						state_q <= S_SIFT_L;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MHPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "entry count above capacity")
	`MHPQ_ASSERT_NOW(a_waddr_bound, we, 32'(waddr) < CAPACITY, "write beyond store")
	`MHPQ_ASSERT_NEXT(a_append, append_go, !built_q && count_q == $past(count_q) + CW'(1), "lost append")

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the max heap priority queue unit against a heap predictor in the
// bench. The run opens with corner requests: an empty extract, a full fill
// with extreme prices and duplicate keys, an overflow, and a rebuild after a
// late append. Random append bursts, overflow runs, drains and mixed traffic
// follow. Both sides idle at random, and the result side holds off once for a
// long stretch. Every result is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int HEAP_DEPTH     = mhpq_pkg::DEF_CAPACITY;
	localparam int CLK_PERIOD     = 8;
	localparam int TOTAL_REQUESTS = 1850;
	localparam int LONG_HOLD      = 300;
	localparam int DRAIN_CYCLES   = 64;
	localparam int TIMEOUT_CYCLES = 3000000;

	localparam logic [31:0] PRICE_CORNERS [16] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005, 32'h0000_0005,
		32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0064, 32'h0000_0064,
		32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0003, 32'h0000_0000,
		32'hFFFF_FFFF, 32'h0000_002A, 32'h0000_03E7, 32'h0000_0005
	};

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               func        = mhpq_pkg::FN_APPEND;
	logic [31:0]        item_key    = '0;
	logic [30:0]        item_id     = '0;
	logic [3:0]         item_doors  = '0;
	logic [7:0]         item_series = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic [1:0]         status;
	logic [31:0]        out_key;
	logic signed [31:0] out_id;
	logic [3:0]         out_doors;
	logic [7:0]         out_series;

	max_heap_priority_queue_unit #(
		.CAPACITY(HEAP_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.item_key   (item_key),
		.item_id    (item_id),
		.item_doors (item_doors),
		.item_series(item_series),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.out_key    (out_key),
		.out_id     (out_id),
		.out_doors  (out_doors),
		.out_series (out_series)
	);

	// heap shadow
	mhpq_pkg::entry_t heap_slots [HEAP_DEPTH];
	int               heap_fill    = 0;
	bit               heap_ordered = 1'b1;

	mhpq_pkg::req_t requests_queued [$];
	mhpq_pkg::res_t results_due [$];
	mhpq_pkg::req_t req_on_bus;

	int send_gap        = 0;
	int recv_stall      = 0;
	bit long_hold_done  = 1'b0;
	int requests_sent   = 0;
	int results_checked = 0;
	int mismatches      = 0;
	int n_stored        = 0;
	int n_dropped       = 0;
	int n_extracted     = 0;
	int n_empty         = 0;

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic void swap_slots(int a, int b);
		mhpq_pkg::entry_t t;
		t = heap_slots[a];
		heap_slots[a] = heap_slots[b];
		heap_slots[b] = t;
	endfunction

	function automatic void sink_slot(int node);
		int best;
		int left;
		int right;
		bit settled;
		settled = 1'b0;
		while (!settled && node < heap_fill) begin
			best = node;
			left = 2 * node + 1;
			right = 2 * node + 2;
			// a child wins only on a strictly greater price, left tested first
			if (left < heap_fill && heap_slots[best].key < heap_slots[left].key)
				best = left;
			if (right < heap_fill && heap_slots[best].key < heap_slots[right].key)
				best = right;
			if (best == node) begin
				settled = 1'b1;
			end else begin
				swap_slots(node, best);
				node = best;
			end
		end
	endfunction

	function automatic mhpq_pkg::res_t apply_request(mhpq_pkg::req_t r);
		mhpq_pkg::res_t res;
		int last;
		res = '0;
		if (r.func == mhpq_pkg::FN_APPEND) begin
			if (heap_fill >= HEAP_DEPTH) begin
				res.status = mhpq_pkg::ST_FULL;
				n_dropped++;
			end else begin
				heap_slots[heap_fill] = r.entry;
				heap_fill++;
				heap_ordered = 1'b0;
				res.status = mhpq_pkg::ST_STORED;
				n_stored++;
			end
		end else if (heap_fill == 0) begin
			res.status = mhpq_pkg::ST_EMPTY;
			res.id = '1;
			n_empty++;
		end else begin
			if (!heap_ordered) begin
				for (int i = heap_fill / 2; i > 0; i--)
					sink_slot(i - 1);
				heap_ordered = 1'b1;
			end
			last = heap_fill - 1;
			swap_slots(0, last);
			heap_fill = last;
			sink_slot(0);
			res.status = mhpq_pkg::ST_EXTRACTED;
			res.key = heap_slots[last].key;
			res.id = {1'b0, heap_slots[last].id};
			res.doors = heap_slots[last].doors;
			res.series = heap_slots[last].series;
			n_extracted++;
		end
		return res;
	endfunction

	function automatic mhpq_pkg::entry_t random_entry();
		mhpq_pkg::entry_t e;
		int pick;
		pick = $urandom_range(0, 99);
		// narrow key range makes ties common
		if (pick < 25)
			e.key = 32'($urandom_range(0, 3));
		else if (pick < 35)
			e.key = pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
		else
			e.key = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			e.id = '0;
		else if (pick < 10)
			e.id = '1;
		else
			e.id = 31'($urandom);
		e.doors = 4'($urandom_range(0, 15));
		e.series = 8'($urandom_range(0, 255));
		return e;
	endfunction

	function automatic void push_request(logic fn, mhpq_pkg::entry_t e);
		mhpq_pkg::req_t r;
		r.func = fn;
		r.entry = e;
		requests_queued.push_back(r);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : driver
		int pick;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				results_due.push_back(apply_request(req_on_bus));
				requests_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (requests_queued.size() > 0) begin
					req_on_bus = requests_queued.pop_front();
					func <= req_on_bus.func;
					item_key <= req_on_bus.entry.key;
					item_id <= req_on_bus.entry.id;
					item_doors <= req_on_bus.entry.doors;
					item_series <= req_on_bus.entry.series;
					in_valid <= 1'b1;
					// gap taken after this request is accepted
					pick = $urandom_range(0, 99);
					if ((requests_sent / 150) % 3 == 1 || pick < 55)
						send_gap = 0;
					else if (pick < 90)
						send_gap = $urandom_range(1, 3);
					else
						send_gap = $urandom_range(10, 40);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		mhpq_pkg::res_t want;
		int pick;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					$error("result with no request pending: status %0d", status);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_key", want.key, out_key);
					check_field("out_id", want.id, out_id);
					check_field("out_doors", 32'(want.doors), 32'(out_doors));
					check_field("out_series", 32'(want.series), 32'(out_series));
					results_checked++;
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && results_checked >= 200) begin
				// long hold-off so the unit backs up and stalls its input
				long_hold_done = 1'b1;
				recv_stall = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else begin
				pick = $urandom_range(0, 99);
				if ((results_checked / 128) % 4 == 2 || pick < 60) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					recv_stall = (pick < 92) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				end
			end
		end
	end

	initial begin : stimulus
		mhpq_pkg::entry_t e;
		int mode;
		int burst;
		int k;
		int total_requests;

		push_request(mhpq_pkg::FN_EXTRACT, random_entry());
		// fill to capacity with extreme prices and duplicates
		for (k = 0; k < HEAP_DEPTH; k++) begin
			e.key = PRICE_CORNERS[k];
			e.id = (k == 1) ? 31'h7FFF_FFFF : 31'(k * 13);
			e.doors = 4'(k);
			e.series = k[0] ? 8'hFF : 8'(k);
			push_request(mhpq_pkg::FN_APPEND, e);
		end
		push_request(mhpq_pkg::FN_APPEND, random_entry());
		for (k = 0; k < 3; k++)
			push_request(mhpq_pkg::FN_EXTRACT, random_entry());
		push_request(mhpq_pkg::FN_APPEND, random_entry());
		for (k = 0; k < 2; k++)
			push_request(mhpq_pkg::FN_EXTRACT, random_entry());

		while (requests_queued.size() < TOTAL_REQUESTS) begin
			mode = $urandom_range(0, 99);
			if (mode < 40) begin
				burst = $urandom_range(1, 20);
				for (k = 0; k < burst; k++)
					push_request(mhpq_pkg::FN_APPEND, random_entry());
				burst = $urandom_range(1, 20);
				for (k = 0; k < burst; k++)
					push_request(mhpq_pkg::FN_EXTRACT, random_entry());
			end else if (mode < 60) begin
				// run past capacity, then empty out
				burst = $urandom_range(17, 22);
				for (k = 0; k < burst; k++)
					push_request(mhpq_pkg::FN_APPEND, random_entry());
				burst = $urandom_range(17, 20);
				for (k = 0; k < burst; k++)
					push_request(mhpq_pkg::FN_EXTRACT, random_entry());
			end else if (mode < 80) begin
				burst = $urandom_range(10, 30);
				for (k = 0; k < burst; k++)
					push_request(logic'($urandom_range(0, 1)), random_entry());
			end else begin
				burst = $urandom_range(1, 20);
				for (k = 0; k < burst; k++)
					push_request(mhpq_pkg::FN_EXTRACT, random_entry());
			end
		end
		total_requests = requests_queued.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (results_checked < total_requests)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d stored, %0d dropped on full heap,",
			requests_sent, n_stored, n_dropped);
		$display("%0d extracted, %0d on empty heap, %0d results checked, %0d mismatches",
			n_extracted, n_empty, results_checked, mismatches);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_mem.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue_unit.sv
verif/testbench.sv
